// ===== rtl/atrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// atrsp_pkg
// Shared types, character codes, mode and event codes for the AT response
// stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package atrsp_pkg;

  // line position wraps at this count
  localparam int LINE_LIMIT = 128;
  localparam int LINE_IDX_W = $clog2(LINE_LIMIT);
  // one extra bit so the line length itself fits
  localparam int LINE_LEN_W = LINE_IDX_W + 1;

  localparam int HIST_DEPTH = 7;
  localparam int CNT_W      = 16;

  typedef logic [7:0]            byte_t;
  typedef logic [1:0]            kind_t;
  typedef logic [1:0]            mode_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [LINE_IDX_W-1:0] line_idx_t;

  // parser modes
  localparam mode_t MODE_NORMAL  = 2'd0;
  localparam mode_t MODE_LENGTH  = 2'd1;
  localparam mode_t MODE_PAYLOAD = 2'd2;

  // result kinds
  localparam kind_t EV_OK    = 2'd0;
  localparam kind_t EV_ERROR = 2'd1;
  localparam kind_t EV_DATA  = 2'd2;

  // characters
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_O     = 8'h4F;
  localparam byte_t CH_K     = 8'h4B;
  localparam byte_t CH_E     = 8'h45;
  localparam byte_t CH_R     = 8'h52;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_I     = 8'h49;
  localparam byte_t CH_P     = 8'h50;
  localparam byte_t CH_D     = 8'h44;
  localparam byte_t CH_COMMA = 8'h2C;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_ZERO  = 8'h30;

  // minimum line index for each pattern to lie inside the current line
  localparam line_idx_t OK_MIN_IDX  = LINE_IDX_W'(3);
  localparam line_idx_t ERR_MIN_IDX = LINE_IDX_W'(6);
  localparam line_idx_t IPD_MIN_IDX = LINE_IDX_W'(4);

  typedef struct packed {
    kind_t event_kind;
    byte_t payload_byte;
    logic  payload_last;
    byte_t response_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/atrsp_if.sv =====
// ----------------------------------------------------------------------------
// atrsp_if
// Valid/ready channel interfaces for received bytes and parser results.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrsp_in_if import atrsp_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atrsp_out_if import atrsp_pkg::*;;
  logic  valid;
  logic  ready;
  kind_t event_kind;
  byte_t payload_byte;
  logic  payload_last;
  byte_t response_length;

  modport source (output valid, output event_kind, output payload_byte,
                  output payload_last, output response_length, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input payload_last, input response_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/atrsp_in_reg.sv =====
// ----------------------------------------------------------------------------
// atrsp_in_reg
// Input register stage: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module atrsp_in_reg import atrsp_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  input  byte_t in_byte,
  output logic  in_ready,
  input  wire   take,
  output logic  held_valid,
  output byte_t held_byte
);

  logic  vld_r;
  byte_t byte_r;

  // stage can load when empty or being drained this cycle
  assign in_ready   = !vld_r || take;
  assign held_valid = vld_r;
  assign held_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/atrsp_parser.sv =====
// ----------------------------------------------------------------------------
// atrsp_parser
// Parser state and single-pass next-state logic for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module atrsp_parser import atrsp_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  wire     step,
  input  byte_t   b,
  output logic    res_valid,
  output result_t res
);

  mode_t     mode_r, mode_nxt;
  line_idx_t idx_r, idx_nxt;
  byte_t     hist_r   [HIST_DEPTH];
  byte_t     hist_nxt [HIST_DEPTH];
  cnt_t      acc_r, acc_nxt;
  cnt_t      left_r, left_nxt;

  logic [LINE_LEN_W-1:0] line_len;
  line_idx_t             idx_inc;
  cnt_t                  left_dec;
  logic                  crlf, ok_m, err_m, ipd_m;

  // line length counts the current byte; index wraps at the limit
  assign line_len = LINE_LEN_W'(idx_r) + LINE_LEN_W'(1);
  assign idx_inc  = (line_len >= LINE_LEN_W'(LINE_LIMIT)) ? '0
                                                          : line_len[LINE_IDX_W-1:0];
  assign left_dec = left_r - cnt_t'(1);

  // history before the shift: hist_r[0] is the previous byte
  assign crlf  = (idx_r != '0) && (hist_r[0] == CH_CR) && (b == CH_LF);
  assign ok_m  = (hist_r[1] == CH_K) && (hist_r[2] == CH_O) && (idx_r >= OK_MIN_IDX);
  assign err_m = (hist_r[1] == CH_R) && (hist_r[2] == CH_O) && (hist_r[3] == CH_R)
              && (hist_r[4] == CH_R) && (hist_r[5] == CH_E) && (idx_r >= ERR_MIN_IDX);
  assign ipd_m = (b == CH_COMMA) && (hist_r[0] == CH_D) && (hist_r[1] == CH_P)
              && (hist_r[2] == CH_I) && (hist_r[3] == CH_PLUS) && (idx_r >= IPD_MIN_IDX);

  always_comb begin
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    hist_nxt  = hist_r;
    res_valid = 1'b0;
    res       = '0;

    unique case (mode_r)
      MODE_LENGTH: begin
        if (b == CH_COLON) begin
          left_nxt = acc_r;
          acc_nxt  = '0;
          mode_nxt = (acc_r != '0) ? MODE_PAYLOAD : MODE_NORMAL;
        end else begin
          // acc * 10 + digit, no digit check, wraps at 16 bits
          acc_nxt = (acc_r << 3) + (acc_r << 1) + cnt_t'(b) - cnt_t'(CH_ZERO);
        end
      end
      MODE_PAYLOAD: begin
        left_nxt             = left_dec;
        res_valid            = 1'b1;
        res.event_kind       = EV_DATA;
        res.payload_byte     = b;
        res.payload_last     = (left_dec == '0);
        if (left_dec == '0) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        // normal line mode, unused code too
        mode_nxt    = MODE_NORMAL;
        hist_nxt[0] = b;
        for (int k = 1; k < HIST_DEPTH; k++) begin
          hist_nxt[k] = hist_r[k-1];
        end
        idx_nxt = idx_inc;
        if (crlf && (ok_m || err_m)) begin
          res_valid           = 1'b1;
          res.event_kind      = ok_m ? EV_OK : EV_ERROR;
          res.response_length = 8'(line_len);
          idx_nxt             = '0;
        end else if (ipd_m) begin
          mode_nxt = MODE_LENGTH;
          acc_nxt  = '0;
          idx_nxt  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      idx_r  <= '0;
      acc_r  <= '0;
      left_r <= '0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
    end else if (step) begin
      mode_r <= mode_nxt;
      idx_r  <= idx_nxt;
      acc_r  <= acc_nxt;
      left_r <= left_nxt;
      hist_r <= hist_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/atrsp_out_reg.sv =====
// ----------------------------------------------------------------------------
// atrsp_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module atrsp_out_reg import atrsp_pkg::*; (
  input  wire     clk,
  input  wire     rst_n,
  input  wire     load,
  input  wire     load_valid,
  input  result_t load_data,
  output logic    free,
  output logic    out_valid,
  input  wire     out_ready,
  output result_t out_data
);

  logic    vld_r;
  result_t data_r;

  assign free      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= load && load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/at_response_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// at_response_stream_parser_core
// Parses a modem byte stream: reports OK / ERROR response lines with their
// length and forwards +IPD payload bytes, flagging the last one.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------------
//  in_ch    | in  | rx_byte
//  out_ch   | out | event_kind, payload_byte, payload_last, response_length
//
//  one byte per cycle sustained while out_ch is ready; a byte is parsed in
//  the input register and its result is in the result register the cycle after
//  zero or one result beat per byte; bytes with no result just advance state
//  rst_n is synchronous: mode goes to normal line, line index, history,
//  length and payload counters clear, both stages empty
//  a stalled out_ch holds the result register; the input register keeps its
//  byte, or loads one if empty, then in_ch.ready drops until the result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module at_response_stream_parser_core import atrsp_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  atrsp_in_if.sink      in_ch,
  atrsp_out_if.source   out_ch
);

  logic    held_valid;
  byte_t   held_byte;
  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_data;

  // a byte is parsed when it sits in the input register and the
  // result register can take whatever it produces
  assign step = held_valid && out_free;

  atrsp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_byte    (in_ch.rx_byte),
    .in_ready   (in_ch.ready),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // state update and result decode in one pass
  atrsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .b         (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  atrsp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .load_valid (res_valid),
    .load_data  (res),
    .free       (out_free),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data)
  );

  // unpack the result beat onto the channel fields
  assign out_ch.event_kind      = out_data.event_kind;
  assign out_ch.payload_byte    = out_data.payload_byte;
  assign out_ch.payload_last    = out_data.payload_last;
  assign out_ch.response_length = out_data.response_length;

endmodule

`default_nettype wire
